### hdl/mmdc_pkg.sv
// Shared types and constants of the memory-mapped device controller.
`timescale 1ns / 1ps
package mmdc_pkg;
  localparam int NumDevices = 16;
  localparam int DevW       = 4;
  localparam int TimeWidth  = 32;
  localparam int DataW      = 16;
  localparam int CfgW       = 64;
  localparam logic [15:0] VecBase = 16'hFFC0;

  typedef enum logic [2:0] {
    OP_READ_WORD  = 3'd0,
    OP_READ_BYTE  = 3'd1,
    OP_WRITE_WORD = 3'd2,
    OP_WRITE_BYTE = 3'd3,
    OP_ARRIVAL    = 3'd4,
    OP_TICK       = 3'd5,
    OP_CHECK      = 3'd6,
    OP_UNUSED     = 3'd7
  } opcode_t;

  typedef enum logic [1:0] {
    KIND_BUS   = 2'd0,
    KIND_DONE  = 2'd1,
    KIND_IRQ   = 2'd2,
    KIND_RSVD  = 2'd3
  } kind_t;

  typedef enum logic [2:0] {
    REG_INPUT_MASK = 3'd0,
    REG_PROC_A     = 3'd1,
    REG_PROC_B     = 3'd2,
    REG_PROC_C     = 3'd3,
    REG_PROC_D     = 3'd4
  } reg_idx_t;

  typedef enum logic [1:0] {
    ST_IDLE  = 2'd0,
    ST_SCAN  = 2'd1,
    ST_FLUSH = 2'd2
  } state_t;

  typedef enum logic {
    ALU_START = 1'b0,
    ALU_DUE   = 1'b1
  } alu_sel_t;
endpackage

### hdl/mmdc_alu.sv
// Shared time unit: adds a duration to the current time and compares against an end time.
`timescale 1ns / 1ps
module mmdc_alu (
  input  logic                           sel,
  input  logic [mmdc_pkg::TimeWidth-1:0] now,
  input  logic [15:0]                    duration,
  input  logic [mmdc_pkg::TimeWidth-1:0] deadline,
  output logic [mmdc_pkg::TimeWidth-1:0] sum,
  output logic                           due
);
  logic [mmdc_pkg::TimeWidth-1:0] opb;

  always_comb begin
    if (sel == mmdc_pkg::ALU_DUE) begin
      opb = deadline;
    end else begin
      opb = mmdc_pkg::TimeWidth'(duration);
    end
  end

  assign sum = now + opb;
  assign due = (now >= opb);
endmodule

### hdl/memory_mapped_device_controller_core.sv
// Top level of the memory-mapped device controller.
// Usage:
//  - Configuration: cfg_we, cfg_index, cfg_data write a register, only while
//    busy is low. Writing the input mask also sets each ready bit to the mask's complement.
//  - Input: a transaction is taken when start is high and busy is low.
//  - Results: out_valid marks each result for exactly one cycle; out_last marks the last
//    result of a transaction. The receiver cannot stall the block.
//  - Bus access, arrival and check leave busy low; their result (if any) appears the
//    cycle after acceptance.
//  - Tick: one device per cycle is tested on the shared compare unit, all 16 devices in
//    the scan state, then the flush state, with busy high in both; completions appear in
//    ascending order via the held and output registers, the last in the cycle after flush.
//  - One transaction per cycle is taken, except that a tick keeps busy high through its
//    scan and flush states.
//  - Reset (rst_n low, synchronous) clears all device state and configuration.
`timescale 1ns / 1ps
module memory_mapped_device_controller_core (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [63:0] cfg_data,
  input  logic        start,
  output logic        busy,
  input  logic [2:0]  in_opcode,
  input  logic [4:0]  in_address,
  input  logic [15:0] in_write_data,
  input  logic [3:0]  in_arrival_device,
  input  logic [7:0]  in_arrival_data,
  input  logic [31:0] in_current_time,
  input  logic        in_gie,
  output logic        out_valid,
  output logic [1:0]  out_kind,
  output logic [3:0]  out_device,
  output logic [15:0] out_data,
  output logic        out_overflow,
  output logic        out_irq_valid,
  output logic [15:0] out_vector_address,
  output logic        out_bad_access,
  output logic        out_last
);
  localparam int N  = mmdc_pkg::NumDevices;
  localparam int TW = mmdc_pkg::TimeWidth;

  mmdc_pkg::state_t state_r, state_nxt;
  logic [3:0]  idx_r, idx_nxt;
  logic [TW-1:0] now_r, now_nxt;

  logic [15:0] input_mask_r, input_mask_nxt;
  logic [63:0] proc_r [4];
  logic [63:0] proc_nxt [4];
  logic [15:0] en_r, en_nxt, rdy_r, rdy_nxt, ovf_r, ovf_nxt, act_r, act_nxt;
  logic [15:0] pend_r, pend_nxt;
  logic [15:0] dreg_r [N];
  logic [15:0] dreg_nxt [N];
  logic [TW-1:0] endt_r [N];
  logic [TW-1:0] endt_nxt [N];

  logic        held_v_r, held_v_nxt;
  logic [3:0]  held_dev_r, held_dev_nxt;
  logic [15:0] held_data_r, held_data_nxt;
  logic        held_ovf_r, held_ovf_nxt;

  logic        ov_r, ov_nxt, ol_r, ol_nxt, oo_r, oo_nxt, oi_r, oi_nxt, ob_r, ob_nxt;
  logic [1:0]  ok_r, ok_nxt;
  logic [3:0]  od_r, od_nxt;
  logic [15:0] odata_r, odata_nxt, ovec_r, ovec_nxt;

  logic        alu_sel;
  logic [3:0]  alu_dev;
  logic [TW-1:0] alu_now, alu_sum;
  logic        alu_due;
  logic [15:0] dur;

  logic [3:0]  bdev;
  logic [15:0] want, am;
  logic        is_byte, is_read;
  logic        found;
  logic [3:0]  pick;

  assign alu_dev = (state_r == mmdc_pkg::ST_SCAN) ? idx_r : in_address[4:1];
  assign alu_now = (state_r == mmdc_pkg::ST_SCAN) ? now_r : in_current_time;
  assign alu_sel = (state_r == mmdc_pkg::ST_SCAN) ? mmdc_pkg::ALU_DUE : mmdc_pkg::ALU_START;
  assign dur = proc_r[alu_dev[3:2]][{alu_dev[1:0], 4'b0000} +: 16];

  mmdc_alu u_alu (
    .sel(alu_sel), .now(alu_now), .duration(dur), .deadline(endt_r[alu_dev]),
    .sum(alu_sum), .due(alu_due)
  );

  assign bdev    = in_address[4:1];
  assign am      = 16'(1) << in_arrival_device;
  assign is_byte = (in_opcode == mmdc_pkg::OP_READ_BYTE) || (in_opcode == mmdc_pkg::OP_WRITE_BYTE);
  assign is_read = (in_opcode == mmdc_pkg::OP_READ_WORD) || (in_opcode == mmdc_pkg::OP_READ_BYTE);
  assign want    = ((rdy_r & input_mask_r) | pend_r) & en_r;

  always_comb begin
    found = 1'b0;
    pick  = '0;
    for (int i = N - 1; i >= 0; i--) begin
      if (want[i]) begin
        found = 1'b1;
        pick  = 4'(i);
      end
    end
  end

  assign busy = (state_r != mmdc_pkg::ST_IDLE);

  always_comb begin
    state_nxt = state_r;
    idx_nxt = idx_r;
    now_nxt = now_r;
    input_mask_nxt = input_mask_r;
    proc_nxt = proc_r;
    en_nxt = en_r; rdy_nxt = rdy_r; ovf_nxt = ovf_r; act_nxt = act_r; pend_nxt = pend_r;
    dreg_nxt = dreg_r;
    endt_nxt = endt_r;
    held_v_nxt = held_v_r; held_dev_nxt = held_dev_r;
    held_data_nxt = held_data_r; held_ovf_nxt = held_ovf_r;
    ov_nxt = 1'b0; ol_nxt = 1'b0; ok_nxt = mmdc_pkg::KIND_BUS; od_nxt = '0;
    odata_nxt = '0; oo_nxt = 1'b0; oi_nxt = 1'b0; ovec_nxt = '0; ob_nxt = 1'b0;

    case (state_r)
      mmdc_pkg::ST_IDLE: begin
        if (cfg_we) begin
          case (cfg_index)
            mmdc_pkg::REG_INPUT_MASK: begin
              input_mask_nxt = cfg_data[15:0];
              rdy_nxt = ~cfg_data[15:0];
            end
            mmdc_pkg::REG_PROC_A: proc_nxt[0] = cfg_data;
            mmdc_pkg::REG_PROC_B: proc_nxt[1] = cfg_data;
            mmdc_pkg::REG_PROC_C: proc_nxt[2] = cfg_data;
            mmdc_pkg::REG_PROC_D: proc_nxt[3] = cfg_data;
            default: ;
          endcase
        end
        if (start) begin
          case (in_opcode)
            mmdc_pkg::OP_READ_WORD, mmdc_pkg::OP_READ_BYTE,
            mmdc_pkg::OP_WRITE_WORD, mmdc_pkg::OP_WRITE_BYTE: begin
              ov_nxt = 1'b1; ol_nxt = 1'b1; od_nxt = bdev;
              if (!in_address[0]) begin
                if (is_byte) begin
                  ob_nxt = 1'b1;
                end else if (is_read) begin
                  odata_nxt = {12'b0, ovf_r[bdev], rdy_r[bdev], input_mask_r[bdev], en_r[bdev]};
                end else begin
                  en_nxt[bdev] = in_write_data[0];
                end
              end else if (input_mask_r[bdev]) begin
                if (is_read) begin
                  rdy_nxt[bdev] = 1'b0;
                  odata_nxt = is_byte ? {8'b0, dreg_r[bdev][7:0]} : dreg_r[bdev];
                end
              end else if (!is_read) begin
                ovf_nxt[bdev] = ~rdy_r[bdev];
                rdy_nxt[bdev] = 1'b0;
                dreg_nxt[bdev] = is_byte ? {8'b0, in_write_data[7:0]} : in_write_data;
                act_nxt[bdev] = 1'b1;
                endt_nxt[bdev] = alu_sum;
              end
            end
            mmdc_pkg::OP_ARRIVAL: begin
              ovf_nxt = (ovf_r & ~am) | (rdy_r & am);
              rdy_nxt = rdy_r | am;
              dreg_nxt[in_arrival_device] = {8'b0, in_arrival_data};
            end
            mmdc_pkg::OP_TICK: begin
              state_nxt = mmdc_pkg::ST_SCAN;
              idx_nxt = '0;
              now_nxt = in_current_time;
              held_v_nxt = 1'b0;
            end
            mmdc_pkg::OP_CHECK: begin
              ov_nxt = 1'b1; ol_nxt = 1'b1; ok_nxt = mmdc_pkg::KIND_IRQ;
              if (in_gie && found) begin
                pend_nxt[pick] = 1'b0;
                oi_nxt = 1'b1;
                od_nxt = pick;
                ovec_nxt = mmdc_pkg::VecBase + {11'b0, pick, 1'b0};
              end
            end
            default: ;
          endcase
        end
      end
      mmdc_pkg::ST_SCAN: begin
        if (act_r[idx_r] && alu_due) begin
          if (en_r[idx_r]) pend_nxt[idx_r] = 1'b1;
          rdy_nxt[idx_r] = 1'b1;
          act_nxt[idx_r] = 1'b0;
          endt_nxt[idx_r] = '0;
          if (held_v_r) begin
            ov_nxt = 1'b1; ok_nxt = mmdc_pkg::KIND_DONE; od_nxt = held_dev_r;
            odata_nxt = held_data_r; oo_nxt = held_ovf_r;
          end
          held_v_nxt = 1'b1;
          held_dev_nxt = idx_r;
          held_data_nxt = dreg_r[idx_r];
          held_ovf_nxt = ovf_r[idx_r];
        end
        idx_nxt = idx_r + 4'd1;
        if (idx_r == 4'(N - 1)) state_nxt = mmdc_pkg::ST_FLUSH;
      end
      mmdc_pkg::ST_FLUSH: begin
        if (held_v_r) begin
          ov_nxt = 1'b1; ol_nxt = 1'b1; ok_nxt = mmdc_pkg::KIND_DONE; od_nxt = held_dev_r;
          odata_nxt = held_data_r; oo_nxt = held_ovf_r;
        end
        held_v_nxt = 1'b0;
        idx_nxt = '0;
        state_nxt = mmdc_pkg::ST_IDLE;
      end
      default: state_nxt = mmdc_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= mmdc_pkg::ST_IDLE;
      idx_r <= '0;
      input_mask_r <= '0;
      for (int i = 0; i < 4; i++) proc_r[i] <= '0;
      en_r <= '0; rdy_r <= '0; ovf_r <= '0; act_r <= '0; pend_r <= '0;
      for (int i = 0; i < N; i++) begin
        dreg_r[i] <= '0;
        endt_r[i] <= '0;
      end
      held_v_r <= 1'b0;
      ov_r <= 1'b0;
      ol_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      idx_r <= idx_nxt;
      input_mask_r <= input_mask_nxt;
      proc_r <= proc_nxt;
      en_r <= en_nxt; rdy_r <= rdy_nxt; ovf_r <= ovf_nxt; act_r <= act_nxt; pend_r <= pend_nxt;
      dreg_r <= dreg_nxt;
      endt_r <= endt_nxt;
      held_v_r <= held_v_nxt;
      ov_r <= ov_nxt;
      ol_r <= ol_nxt;
    end
  end

  always_ff @(posedge clk) begin
    now_r <= now_nxt;
    held_dev_r <= held_dev_nxt;
    held_data_r <= held_data_nxt;
    held_ovf_r <= held_ovf_nxt;
    ok_r <= ok_nxt; od_r <= od_nxt; odata_r <= odata_nxt; oo_r <= oo_nxt;
    oi_r <= oi_nxt; ovec_r <= ovec_nxt; ob_r <= ob_nxt;
  end

  assign out_valid          = ov_r;
  assign out_last           = ol_r;
  assign out_kind           = ok_r;
  assign out_device         = od_r;
  assign out_data           = odata_r;
  assign out_overflow       = oo_r;
  assign out_irq_valid      = oi_r;
  assign out_vector_address = ovec_r;
  assign out_bad_access     = ob_r;

  a_idle_idx: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == mmdc_pkg::ST_IDLE |-> idx_r == 4'd0)
    else $error("scan index not cleared in idle");
  a_scan_no_last: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == mmdc_pkg::ST_SCAN && $past(state_r) == mmdc_pkg::ST_SCAN) |-> !ol_r)
    else $error("last flag during tick scan");
  a_irq_kind: assert property (@(posedge clk) disable iff (!rst_n)
    oi_r && ov_r |-> ok_r == mmdc_pkg::KIND_IRQ)
    else $error("interrupt outside check result");
  a_flush_end: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == mmdc_pkg::ST_FLUSH |=> state_r == mmdc_pkg::ST_IDLE && !held_v_r)
    else $error("flush did not retire held transaction");
endmodule
